// File: design/lad_pkg.sv
// Shared types, constants and register codes of the line averaging deinterlacer.
package lad_pkg;

  localparam int unsigned MaxLineBytes  = 16384;
  localparam int unsigned MaxFieldLines = 2048;

  localparam int unsigned ColW   = $clog2(MaxLineBytes);
  localparam int unsigned LineW  = $clog2(MaxFieldLines);
  localparam int unsigned RowW   = LineW + 1;
  localparam int unsigned LbW    = 15;
  localparam int unsigned FlW    = 12;
  localparam int unsigned CfgW   = 15;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned PixW   = 8;
  localparam int unsigned OutColW = 14;

  localparam logic [LbW-1:0] LineBytesReset  = LbW'(7680);
  localparam logic [FlW-1:0] FieldLinesReset = FlW'(540);

  typedef enum logic [CfgIdxW-1:0] {
    CfgLineBytes  = 2'd0,
    CfgFieldLines = 2'd1
  } lad_cfg_idx_e;

  typedef enum logic [1:0] {
    PhCopy = 2'd0,
    PhAvg  = 2'd1,
    PhDup  = 2'd2
  } lad_phase_e;

  // One accepted byte with its place in the frame and the writes it causes.
  typedef struct packed {
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
    logic [PixW-1:0] pix;
    logic            has_avg;
    logic            has_dup;
  } lad_item_t;

  typedef struct packed {
    logic       busy;
    lad_phase_e phase;
  } lad_emit_stat_t;

endpackage

// File: design/line_average_deinterlacer.sv
// Top level of the line averaging deinterlacer.
//
// The input channel takes one byte of a video field per beat, in raster
// order, with frame_start_i set on the first byte of a field. Each byte
// turns into one to three output beats, each a frame write: row 2k holds
// the copied byte, row 2k-1 the truncated average of this byte and the byte
// one field line above it, and after the last field line row 2k+1 holds a
// copy again. last_of_run_o marks the final write caused by one byte.
// The configuration port sets bytes per line and lines per field; write it
// only while no byte is in flight.
// An accepted byte is counted and its column of the line store is read and
// overwritten in the acceptance cycle; the byte is then held in the emit
// stage and its writes go from there into the output register, which moves
// one write per cycle while the receiver does not stall. A byte causes one
// to three writes, two for an ordinary line. The next byte is taken in the
// cycle that the last write of the current one enters the output register.
// When the receiver stalls, the output beat holds and the block stops taking
// input beats once its holding stage is full. Reset clears the counters and
// both handshake stages and loads the reset configuration; the line store
// keeps its contents and needs no clearing, as field line 0 never averages.
module line_average_deinterlacer import lad_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [PixW-1:0]    pixel_byte_i,
  input  logic               frame_start_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [RowW-1:0]    frame_row_o,
  output logic [OutColW-1:0] frame_column_o,
  output logic [PixW-1:0]    byte_value_o,
  output logic               last_of_run_o
);

  lad_item_t      item;
  lad_emit_stat_t stat;
  logic           free;
  logic           accept;
  logic [PixW-1:0] above;

  assign in_stall_o = !free;
  assign accept     = in_valid_i && free;

  // Position counters and the line length and field length registers.
  lad_position u_position (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_wdata_i,
    .accept_i      (accept),
    .pixel_byte_i,
    .frame_start_i,
    .item_o        (item)
  );

  // The store hands back the byte one field line above in the next cycle.
  lad_line_store u_store (
    .clk_i,
    .en_i    (accept),
    .addr_i  (item.col),
    .wdata_i (item.pix),
    .rdata_o (above)
  );

  lad_emit u_emit (
    .clk_i,
    .rst_ni,
    .accept_i       (accept),
    .item_i         (item),
    .above_i        (above),
    .free_o         (free),
    .stat_o         (stat),
    .out_valid_o,
    .out_stall_i,
    .frame_row_o,
    .frame_column_o,
    .byte_value_o,
    .last_of_run_o
  );

  // An accepted byte always starts with its copy write.
  a_accept_starts_copy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> stat.busy && stat.phase == PhCopy)
    else $error("accepted byte did not start with its copy write");

  // A shown write that is not the last of its byte leaves that byte pending.
  a_partial_run_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_of_run_o |-> stat.busy)
    else $error("byte retired before its last write");

  // A new byte may enter a busy block only when the output register moves.
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.busy && !in_stall_o |-> !(out_valid_o && out_stall_i))
    else $error("input taken while the held byte could not finish");

endmodule

// File: design/lad_position.sv
// Configuration registers and the column and field line counters.
module lad_position import lad_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  input  logic               accept_i,
  input  logic [PixW-1:0]    pixel_byte_i,
  input  logic               frame_start_i,
  output lad_item_t          item_o
);

  logic [LbW-1:0]   lb_q;
  logic [FlW-1:0]   fl_q;
  logic [LbW-1:0]   lb_eff;
  logic [FlW-1:0]   fl_eff;
  logic [ColW-1:0]  col_q, col_d;
  logic [LineW-1:0] line_q, line_d;
  logic [ColW-1:0]  c0, c1;
  logic [FlW-1:0]   l0, l1, l2, ln;
  logic [LbW-1:0]   cn;
  logic             wrap1, wrap2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lb_q <= LineBytesReset;
      fl_q <= FieldLinesReset;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CfgLineBytes) begin
        lb_q <= cfg_wdata_i[LbW-1:0];
      end else if (cfg_index_i == CfgFieldLines) begin
        fl_q <= cfg_wdata_i[FlW-1:0];
      end
    end
  end

  // Out of range lengths are clamped to the supported span.
  always_comb begin
    if (lb_q == '0) begin
      lb_eff = LbW'(1);
    end else if (lb_q > LbW'(MaxLineBytes)) begin
      lb_eff = LbW'(MaxLineBytes);
    end else begin
      lb_eff = lb_q;
    end
    if (fl_q == '0) begin
      fl_eff = FlW'(1);
    end else if (fl_q > FlW'(MaxFieldLines)) begin
      fl_eff = FlW'(MaxFieldLines);
    end else begin
      fl_eff = fl_q;
    end
  end

  always_comb begin
    c0    = frame_start_i ? '0 : col_q;
    l0    = frame_start_i ? '0 : FlW'(line_q);
    wrap1 = LbW'(c0) >= lb_eff;
    c1    = wrap1 ? '0 : c0;
    l1    = wrap1 ? l0 + FlW'(1) : l0;
    l2    = (l1 >= fl_eff) ? '0 : l1;

    item_o.col     = c1;
    item_o.row     = {l2[LineW-1:0], 1'b0};
    item_o.pix     = pixel_byte_i;
    item_o.has_avg = l2 != '0;
    item_o.has_dup = (l2 + FlW'(1)) == fl_eff;

    cn    = LbW'(c1) + LbW'(1);
    ln    = l2 + FlW'(1);
    wrap2 = cn >= lb_eff;
    col_d = wrap2 ? '0 : cn[ColW-1:0];
    if (wrap2) begin
      line_d = (ln >= fl_eff) ? '0 : ln[LineW-1:0];
    end else begin
      line_d = l2[LineW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      line_q <= '0;
    end else if (accept_i) begin
      col_q  <= col_d;
      line_q <= line_d;
    end
  end

endmodule

// File: design/lad_line_store.sv
// Previous field line store: one read-first read and write per accepted byte.
module lad_line_store import lad_pkg::*; (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [ColW-1:0] addr_i,
  input  logic [PixW-1:0] wdata_i,
  output logic [PixW-1:0] rdata_o
);

  logic [PixW-1:0] mem [MaxLineBytes];
  logic [PixW-1:0] rdata_q;

  // The old byte of the column is read in the same cycle the new one is
  // written, so back to back bytes on one column need no forwarding.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rdata_q      <= mem[addr_i];
      mem[addr_i]  <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/lad_emit.sv
// Holds one byte and sends its one to three frame writes through the output register.
module lad_emit import lad_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  lad_item_t          item_i,
  input  logic [PixW-1:0]    above_i,
  output logic               free_o,
  output lad_emit_stat_t     stat_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [RowW-1:0]    frame_row_o,
  output logic [OutColW-1:0] frame_column_o,
  output logic [PixW-1:0]    byte_value_o,
  output logic               last_of_run_o
);

  lad_item_t        item_q;
  logic             busy_q, busy_d;
  lad_phase_e       phase_q, phase_d, phase_nx;
  logic             out_valid_q, out_valid_d;
  logic [RowW-1:0]  row_q, row_d;
  logic [ColW-1:0]  col_q;
  logic [PixW-1:0]  val_q, val_d;
  logic             last_q, more;
  logic             out_ready, emit, done;
  logic [PixW:0]    sum;

  assign out_ready = !out_valid_q || !out_stall_i;
  assign emit      = busy_q && out_ready;
  assign sum       = {1'b0, above_i} + {1'b0, item_q.pix};

  always_comb begin
    more     = 1'b0;
    phase_nx = PhDup;
    row_d    = item_q.row;
    val_d    = item_q.pix;
    unique case (phase_q)
      PhCopy: begin
        more     = item_q.has_avg || item_q.has_dup;
        phase_nx = item_q.has_avg ? PhAvg : PhDup;
      end
      PhAvg: begin
        more  = item_q.has_dup;
        row_d = item_q.row - RowW'(1);
        val_d = sum[PixW:1];
      end
      PhDup: begin
        row_d = item_q.row + RowW'(1);
      end
      default: begin
        more = 1'b0;
      end
    endcase

    done    = emit && !more;
    free_o  = !busy_q || done;
    busy_d  = busy_q;
    phase_d = phase_q;
    if (accept_i) begin
      busy_d  = 1'b1;
      phase_d = PhCopy;
    end else if (done) begin
      busy_d  = 1'b0;
    end else if (emit) begin
      phase_d = phase_nx;
    end
    out_valid_d = out_ready ? emit : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      phase_q     <= PhCopy;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      item_q <= item_i;
    end
    if (emit) begin
      row_q  <= row_d;
      col_q  <= item_q.col;
      val_q  <= val_d;
      last_q <= !more;
    end
  end

  assign stat_o.busy    = busy_q;
  assign stat_o.phase   = phase_q;
  assign out_valid_o    = out_valid_q;
  assign frame_row_o    = row_q;
  assign frame_column_o = OutColW'(col_q);
  assign byte_value_o   = val_q;
  assign last_of_run_o  = last_q;

endmodule

// File: sim/tb_top.sv
// Self-checking testbench for the line averaging deinterlacer.
`timescale 1ns / 1ps

module tb_top;
  import lad_pkg::*;

  localparam int unsigned ResetCycles  = 10;
  localparam int unsigned TotalBytes   = 360;
  localparam int unsigned QuietBytes   = 40;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned DrainLimit   = 5000;
  localparam int unsigned HoldCycles   = 80;
  localparam int unsigned MaxReported  = 200;

  // Indexes past the end of the register list; the block must ignore them.
  localparam logic [CfgIdxW-1:0] CfgSpareLo = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpareHi = 2'd3;

  // One frame write as it leaves the block.
  typedef struct packed {
    logic [RowW-1:0]    row;
    logic [OutColW-1:0] col;
    logic [PixW-1:0]    value;
    logic               last_flag;
  } frame_write_t;

  // Predicts the frame writes of each accepted byte and checks the writes
  // that come out against them, oldest first.
  class frame_write_predictor;
    frame_write_t  expected_writes[$];
    bit [PixW-1:0] line_store [MaxLineBytes];
    bit            store_written [MaxLineBytes];
    int unsigned   column_pos;
    int unsigned   line_pos;
    int unsigned   line_bytes_reg;
    int unsigned   field_lines_reg;
    int unsigned   mismatches;

    function new();
      column_pos      = 0;
      line_pos        = 0;
      line_bytes_reg  = LineBytesReset;
      field_lines_reg = FieldLinesReset;
      mismatches      = 0;
    endfunction

    function int unsigned bytes_per_line();
      if (line_bytes_reg == 0) return 1;
      if (line_bytes_reg > MaxLineBytes) return MaxLineBytes;
      return line_bytes_reg;
    endfunction

    function int unsigned lines_per_field();
      if (field_lines_reg == 0) return 1;
      if (field_lines_reg > MaxFieldLines) return MaxFieldLines;
      return field_lines_reg;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] index, logic [CfgW-1:0] data);
      case (index)
        CfgLineBytes:  line_bytes_reg = data;
        CfgFieldLines: field_lines_reg = data[FlW-1:0];
        default: ;
      endcase
    endfunction

    // Place in the field that the next byte takes, without moving the counters.
    function void locate(input logic start, output int unsigned col,
                         output int unsigned line);
      col  = start ? 0 : column_pos;
      line = start ? 0 : line_pos;
      if (col >= bytes_per_line()) begin
        col  = 0;
        line = line + 1;
      end
      if (line >= lines_per_field()) line = 0;
    endfunction

    // True when the next byte would average with a line store entry that
    // was never written since reset.
    function bit reads_blank(logic start);
      int unsigned col;
      int unsigned line;
      locate(start, col, line);
      return (line > 0) && !store_written[col];
    endfunction

    function void take_byte(logic [PixW-1:0] pix, logic start);
      int unsigned  col;
      int unsigned  line;
      int unsigned  count;
      frame_write_t run [3];
      locate(start, col, line);
      count = 0;
      run[count] = '{row: RowW'(2 * line), col: OutColW'(col), value: pix, last_flag: 1'b0};
      count++;
      if (line > 0) begin
        run[count] = '{row: RowW'(2 * line - 1), col: OutColW'(col),
                       value: PixW'((int'(line_store[col]) + int'(pix)) / 2),
                       last_flag: 1'b0};
        count++;
      end
      if (line + 1 == lines_per_field()) begin
        run[count] = '{row: RowW'(2 * line + 1), col: OutColW'(col), value: pix,
                       last_flag: 1'b0};
        count++;
      end
      run[count - 1].last_flag = 1'b1;
      for (int i = 0; i < count; i++) expected_writes.push_back(run[i]);

      line_store[col]    = pix;
      store_written[col] = 1'b1;
      column_pos = col + 1;
      line_pos   = line;
      if (column_pos >= bytes_per_line()) begin
        column_pos = 0;
        line_pos   = line + 1;
        if (line_pos >= lines_per_field()) line_pos = 0;
      end
    endfunction

    task report(string msg);
      if (mismatches < MaxReported) $display("MISMATCH: %s", msg);
      mismatches++;
    endtask

    task check_write(frame_write_t got);
      frame_write_t want;
      if (expected_writes.size() == 0) begin
        report($sformatf("write with nothing expected: row %0d col %0d value %0d",
                         got.row, got.col, got.value));
        return;
      end
      want = expected_writes.pop_front();
      if (got.row !== want.row)
        report($sformatf("row %0d, expected %0d", got.row, want.row));
      if (got.col !== want.col)
        report($sformatf("column %0d, expected %0d (row %0d)", got.col, want.col, want.row));
      if (got.value !== want.value)
        report($sformatf("value %0d, expected %0d (row %0d col %0d)",
                         got.value, want.value, want.row, want.col));
      if (got.last_flag !== want.last_flag)
        report($sformatf("last_of_run %0b, expected %0b (row %0d col %0d)",
                         got.last_flag, want.last_flag, want.row, want.col));
    endtask
  endclass

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i   = '0;
  logic [CfgW-1:0]    cfg_wdata_i   = '0;
  logic               in_valid_i    = 1'b0;
  logic               in_stall_o;
  logic [PixW-1:0]    pixel_byte_i  = '0;
  logic               frame_start_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i   = 1'b0;
  logic [RowW-1:0]    frame_row_o;
  logic [OutColW-1:0] frame_column_o;
  logic [PixW-1:0]    byte_value_o;
  logic               last_of_run_o;

  frame_write_predictor writes = new();

  int unsigned bytes_sent = 0;
  int unsigned hold_left  = 0;
  int unsigned stall_run  = 0;
  bit          quiet      = 1'b0;
  bit          steady     = 1'b0;

  line_average_deinterlacer u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .pixel_byte_i   (pixel_byte_i),
    .frame_start_i  (frame_start_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .frame_row_o    (frame_row_o),
    .frame_column_o (frame_column_o),
    .byte_value_o   (byte_value_o),
    .last_of_run_o  (last_of_run_o)
  );

  always #2 clk_i = ~clk_i;

  // Receiver: random stall and open runs, a long hold-off on request,
  // and no stalls at all once the run winds down.
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left = hold_left - 1;
    end else if (quiet) begin
      out_stall_i <= 1'b0;
    end else if (stall_run != 0) begin
      stall_run = stall_run - 1;
    end else if ($urandom_range(0, 2) == 0) begin
      out_stall_i <= 1'b1;
      stall_run = $urandom_range(1, 12) - 1;
    end else begin
      out_stall_i <= 1'b0;
      stall_run = $urandom_range(1, 24) - 1;
    end
  end

  // Every output beat taken by the receiver is checked.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      writes.check_write({frame_row_o, frame_column_o, byte_value_o, last_of_run_o});
  end

  function automatic int unsigned sender_gap();
    if (quiet || steady) return 0;
    if ($urandom_range(0, 4) == 0) return $urandom_range(1, 12);
    return 0;
  endfunction

  function automatic logic [PixW-1:0] random_pixel();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return PixW'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic write_reg(input logic [CfgIdxW-1:0] index, input int unsigned data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= index;
    cfg_wdata_i <= CfgW'(data);
    @(posedge clk_i);
    writes.set_reg(index, CfgW'(data));
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Offers one byte and waits for the beat to be taken. A byte that would
  // average against a never-written store entry is turned into a field start.
  task automatic send_byte(input logic [PixW-1:0] pix, input logic start);
    int unsigned gap;
    logic        fs;
    fs  = start;
    gap = sender_gap();
    if (!fs && writes.reads_blank(1'b0)) fs = 1'b1;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    pixel_byte_i  <= pix;
    frame_start_i <= fs;
    do @(posedge clk_i); while (in_stall_o);
    writes.take_byte(pix, fs);
    bytes_sent++;
    if (bytes_sent >= TotalBytes - QuietBytes) quiet = 1'b1;
  endtask

  task automatic send_field(input int unsigned count, input bit noisy);
    logic start;
    for (int unsigned i = 0; i < count; i++) begin
      start = (i == 0) || (noisy && $urandom_range(0, 3) == 0);
      send_byte(random_pixel(), start);
    end
  endtask

  // Lets every expected write come out so that the registers may change.
  task automatic drain_writes();
    int unsigned waited;
    in_valid_i <= 1'b0;
    waited = 0;
    while (writes.expected_writes.size() != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    if (writes.expected_writes.size() != 0) begin
      writes.report($sformatf("%0d expected writes never arrived",
                              writes.expected_writes.size()));
      writes.expected_writes.delete();
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // New small geometry, then a few fields: mostly complete ones, some cut
  // short, some running past their end, and some with stray field starts.
  task automatic random_phase();
    int unsigned lb;
    int unsigned fl;
    int unsigned full;
    int unsigned count;
    int unsigned kind;
    bit          noisy;
    drain_writes();
    kind = $urandom_range(0, 9);
    if (kind == 0) lb = 0;
    else if (kind == 1) lb = $urandom_range(20, 40);
    else lb = $urandom_range(1, 10);
    if (lb >= 20) fl = $urandom_range(1, 2);
    else if ($urandom_range(0, 9) == 0) fl = 0;
    else fl = $urandom_range(1, 5);
    if ($urandom_range(0, 1) == 0) begin
      write_reg(CfgLineBytes, lb);
      write_reg(CfgFieldLines, fl);
    end else begin
      write_reg(CfgFieldLines, fl);
      write_reg(CfgLineBytes, lb);
    end
    if ($urandom_range(0, 7) == 0)
      write_reg($urandom_range(0, 1) ? CfgSpareLo : CfgSpareHi, $urandom_range(0, 32767));
    full = (lb == 0 ? 1 : lb) * (fl == 0 ? 1 : fl);
    repeat ($urandom_range(1, 3)) begin
      kind  = $urandom_range(0, 9);
      noisy = 1'b0;
      if (kind < 7) count = full;
      else if (kind == 7) count = $urandom_range(1, full);
      else if (kind == 8) count = full + $urandom_range(1, (lb == 0 ? 1 : lb));
      else begin
        count = $urandom_range(1, 8);
        noisy = 1'b1;
      end
      send_field(count, noisy);
    end
  endtask

  initial begin
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset geometry: the first bytes of a wide field, extremes of the byte.
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b0);
    drain_writes();

    // Writes to indexes past the register list change nothing. Zero lengths
    // act as one, so each byte is both the first and the last line.
    write_reg(CfgSpareLo, 32767);
    write_reg(CfgSpareHi, 0);
    write_reg(CfgLineBytes, 0);
    write_reg(CfgFieldLines, 0);
    send_byte(8'h5A, 1'b1);
    send_byte(8'hA5, 1'b0);
    drain_writes();

    // Three lines of two bytes: averages at both ends of the range and an
    // odd sum, then two bytes past the end of the field that wrap to line 0.
    write_reg(CfgLineBytes, 2);
    write_reg(CfgFieldLines, 3);
    send_byte(8'd255, 1'b1);
    send_byte(8'd0, 1'b0);
    send_byte(8'd255, 1'b0);
    send_byte(8'd1, 1'b0);
    send_byte(8'd0, 1'b0);
    send_byte(8'd255, 1'b0);
    send_byte(8'd7, 1'b0);
    send_byte(8'd9, 1'b0);
    drain_writes();

    // Shrinking the line under the column counter moves on to the next
    // line; shrinking the field under the line counter wraps to line 0.
    // The field length write carries bits above the register width.
    write_reg(CfgLineBytes, 4);
    write_reg(CfgFieldLines, 32767);
    send_byte(8'd10, 1'b1);
    send_byte(8'd20, 1'b0);
    send_byte(8'd30, 1'b0);
    drain_writes();
    write_reg(CfgLineBytes, 2);
    send_byte(8'd40, 1'b0);
    send_byte(8'd50, 1'b0);
    drain_writes();
    write_reg(CfgFieldLines, 1);
    send_byte(8'd60, 1'b0);
    drain_writes();

    // Largest lengths, over the top and exactly at the limit.
    write_reg(CfgLineBytes, 32767);
    write_reg(CfgFieldLines, MaxFieldLines);
    send_byte(8'd200, 1'b1);
    send_byte(8'd100, 1'b0);
    drain_writes();
    write_reg(CfgLineBytes, MaxLineBytes);
    write_reg(CfgFieldLines, 2);
    send_byte(8'd3, 1'b1);
    drain_writes();

    // The receiver holds off while bytes keep coming, so the block backs up
    // and has to stall its input.
    write_reg(CfgLineBytes, 6);
    write_reg(CfgFieldLines, 3);
    steady    = 1'b1;
    hold_left = HoldCycles;
    send_field(18, 1'b0);
    send_field(18, 1'b0);
    steady = 1'b0;

    while (bytes_sent < TotalBytes) random_phase();
    drain_writes();

    if (writes.mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  initial begin
    #1600000;
    $display("tb_top failed");
    $finish;
  end

endmodule
